// File: rtl/ps2_mouse_packet_cursor_tracker_unit_macros.svh
// assertion macros used by the tracker unit
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check that runs only while out of reset
`define PMCT_ASSERT_RST(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
    else $error("assertion failed");
// check that runs on every edge, reset included
`define PMCT_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("assertion failed");
`else
`define PMCT_ASSERT_RST(lbl, clk_sig, rst_sig, prop)
`define PMCT_ASSERT_ALWAYS(lbl, clk_sig, prop)
`endif

`endif

// File: rtl/pmct_pkg.sv
package pmct_pkg;

  // cursor coordinate width
  localparam int unsigned COORD_WIDTH = 12;
  // signed width of a coordinate plus a 9-bit delta
  localparam int unsigned SUM_WIDTH = COORD_WIDTH + 2;

  // configuration register width and index width
  localparam int unsigned CFG_DATA_WIDTH = 12;
  localparam int unsigned CFG_ADDR_WIDTH = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_X_LIMIT = 2'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_Y_LIMIT = 2'd1;

  // reset values
  localparam logic [COORD_WIDTH-1:0] X_LIMIT_RESET = COORD_WIDTH'(1023);
  localparam logic [COORD_WIDTH-1:0] Y_LIMIT_RESET = COORD_WIDTH'(767);
  localparam logic [COORD_WIDTH-1:0] POS_RESET     = COORD_WIDTH'(100);

  // packet byte position
  localparam logic [1:0] CNT_SYNC   = 2'd0;
  localparam logic [1:0] CNT_SECOND = 2'd1;
  localparam logic [1:0] CNT_THIRD  = 2'd2;
  localparam logic [1:0] CNT_UNUSED = 2'd3;

  // first byte bit positions
  localparam int unsigned BIT_LEFT   = 0;
  localparam int unsigned BIT_RIGHT  = 1;
  localparam int unsigned BIT_MIDDLE = 2;
  localparam int unsigned BIT_SYNC   = 3;
  localparam int unsigned BIT_XSIGN  = 4;
  localparam int unsigned BIT_YSIGN  = 5;
  localparam int unsigned BIT_XOVF   = 6;
  localparam int unsigned BIT_YOVF   = 7;

  // one decoded packet, last field in the lowest bits
  typedef struct packed {
    logic                   position_updated;
    logic [COORD_WIDTH-1:0] cursor_y;
    logic [COORD_WIDTH-1:0] cursor_x;
    logic signed [8:0]      delta_y;
    logic signed [8:0]      delta_x;
    logic                   y_overflow;
    logic                   x_overflow;
    logic                   right_button;
    logic                   middle_button;
    logic                   left_button;
  } out_item_t;

  localparam int unsigned OUT_DATA_WIDTH = (($bits(out_item_t) + 7) / 8) * 8;

endpackage

// File: rtl/ps2_mouse_packet_cursor_tracker_unit.sv
// ps2 mouse packet decoder with cursor tracking
// in_*  : received mouse bytes, one per transaction, in_tdata = rx_byte
// out_* : one transaction per completed three-byte packet carrying buttons,
//         overflow flags, 9-bit signed deltas, the cursor position after the
//         packet and whether the move was accepted
// cfg_* : write-only port, index 0 = x_limit, index 1 = y_limit (12 bits)
// while no packet is open, bytes with bit 3 clear are dropped silently
// the result of a third byte is on out_* in the cycle after it is taken
// throughput: one byte per cycle while no result is stalled; the whole decode and
// bounds check is one registered step between the packet state registers and the result register
// a stalled result holds the output register and in_tready stays low until
// the result is taken; in_tready is high whenever that register is empty
// or being emptied in the same cycle
// reset (synchronous, rst_n low) empties the output register, closes any open
// packet, sets the cursor to (100, 100) and the limits to 1023 and 767
module ps2_mouse_packet_cursor_tracker_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [7:0]                              in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [0] left_button, [1] middle_button, [2] right_button, [3] x_overflow,
  // [4] y_overflow, [13:5] delta_x, [22:14] delta_y, [34:23] cursor_x,
  // [46:35] cursor_y, [47] position_updated
  output logic [pmct_pkg::OUT_DATA_WIDTH-1:0]     out_tdata,
  // configuration writes
  input  logic                                    cfg_we,
  input  logic [pmct_pkg::CFG_ADDR_WIDTH-1:0]     cfg_addr,
  input  logic [pmct_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata
);

`include "ps2_mouse_packet_cursor_tracker_unit_macros.svh"

  localparam int unsigned CW = pmct_pkg::COORD_WIDTH;
  localparam int unsigned SW = pmct_pkg::SUM_WIDTH;

  logic [CW-1:0] x_limit_r, y_limit_r;
  logic [1:0]    byte_count_r, byte_count_nxt;
  logic [7:0]    first_byte_r, first_byte_nxt;
  logic [7:0]    second_byte_r, second_byte_nxt;
  logic [CW-1:0] pos_x_r, pos_x_nxt;
  logic [CW-1:0] pos_y_r, pos_y_nxt;
  logic          out_valid_r, out_valid_nxt;
  pmct_pkg::out_item_t out_item_r, out_item_nxt;

  logic              in_fire;
  logic              pkt_done;
  logic signed [8:0] dx, dy;
  logic signed [SW-1:0] nx, ny;
  logic              ok;

  // handshake
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = pmct_pkg::OUT_DATA_WIDTH'(out_item_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= pmct_pkg::X_LIMIT_RESET;
      y_limit_r <= pmct_pkg::Y_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        pmct_pkg::CFG_X_LIMIT: x_limit_r <= CW'(cfg_wdata);
        pmct_pkg::CFG_Y_LIMIT: y_limit_r <= CW'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // movement decode and bounds check
  always_comb begin
    dx = $signed({first_byte_r[pmct_pkg::BIT_XSIGN], second_byte_r});
    dy = $signed({first_byte_r[pmct_pkg::BIT_YSIGN], in_tdata});
    nx = $signed({2'b00, pos_x_r}) + SW'(dx);
    ny = $signed({2'b00, pos_y_r}) - SW'(dy);
    ok = !first_byte_r[pmct_pkg::BIT_XOVF] && !first_byte_r[pmct_pkg::BIT_YOVF] &&
         !nx[SW-1] && (nx <= $signed({2'b00, x_limit_r})) &&
         !ny[SW-1] && (ny <= $signed({2'b00, y_limit_r}));
  end

  // packet sequencing and cursor update
  always_comb begin
    byte_count_nxt  = byte_count_r;
    first_byte_nxt  = first_byte_r;
    second_byte_nxt = second_byte_r;
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    pkt_done        = 1'b0;
    if (in_fire) begin
      case (byte_count_r)
        pmct_pkg::CNT_SYNC: begin
          if (in_tdata[pmct_pkg::BIT_SYNC]) begin
            first_byte_nxt = in_tdata;
            byte_count_nxt = pmct_pkg::CNT_SECOND;
          end
        end
        pmct_pkg::CNT_SECOND: begin
          second_byte_nxt = in_tdata;
          byte_count_nxt  = pmct_pkg::CNT_THIRD;
        end
        default: begin
          // third byte closes the packet
          pkt_done       = 1'b1;
          byte_count_nxt = pmct_pkg::CNT_SYNC;
          if (ok) begin
            pos_x_nxt = nx[CW-1:0];
            pos_y_nxt = ny[CW-1:0];
          end
        end
      endcase
    end
  end

  // result register contents
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (pkt_done) begin
      out_valid_nxt                  = 1'b1;
      out_item_nxt.left_button       = first_byte_r[pmct_pkg::BIT_LEFT];
      out_item_nxt.middle_button     = first_byte_r[pmct_pkg::BIT_MIDDLE];
      out_item_nxt.right_button      = first_byte_r[pmct_pkg::BIT_RIGHT];
      out_item_nxt.x_overflow        = first_byte_r[pmct_pkg::BIT_XOVF];
      out_item_nxt.y_overflow        = first_byte_r[pmct_pkg::BIT_YOVF];
      out_item_nxt.delta_x           = dx;
      out_item_nxt.delta_y           = dy;
      out_item_nxt.cursor_x          = pos_x_nxt;
      out_item_nxt.cursor_y          = pos_y_nxt;
      out_item_nxt.position_updated  = ok;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= pmct_pkg::CNT_SYNC;
      first_byte_r  <= 8'd0;
      second_byte_r <= 8'd0;
      pos_x_r       <= pmct_pkg::POS_RESET;
      pos_y_r       <= pmct_pkg::POS_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      first_byte_r  <= first_byte_nxt;
      second_byte_r <= second_byte_nxt;
      pos_x_r       <= pos_x_nxt;
      pos_y_r       <= pos_y_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // checks
  `PMCT_ASSERT_RST(a_count_legal, clk, rst_n, byte_count_r != pmct_pkg::CNT_UNUSED)
  `PMCT_ASSERT_RST(a_third_byte_result, clk, rst_n, (in_fire && byte_count_r == pmct_pkg::CNT_THIRD) |=> (out_valid_r && byte_count_r == pmct_pkg::CNT_SYNC))
  `PMCT_ASSERT_RST(a_cursor_held, clk, rst_n, !pkt_done |=> ($stable(pos_x_r) && $stable(pos_y_r)))
  `PMCT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid_r)

endmodule
